/* design/dcs_pkg.sv */
// Shared types and constants for the DCS Golay code detector.
package dcs_pkg;

  // Field widths
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned CODE_W = 9;
  localparam int unsigned WORD_W = 24;
  localparam int unsigned LFSR_W = 12;

  // Stream payload widths
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 16;

  // Golay(23,12) encoder: one cell per LFSR step
  localparam int unsigned GOLAY_STEPS = 12;
  localparam logic [LFSR_W-1:0] GOLAY_POLY = 12'h8ea;

  // Bits 11..9 of a codeword data part (marker bit over two zeros)
  localparam logic [2:0] DATA_MARK = 3'b100;

  // Item kinds on s_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DETECT = 1'b1;

  localparam logic [IDX_W-1:0] LAST_INDEX_RESET = 7'd104;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // What one encoder cell hands to the next
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [LFSR_W-1:0] lfsr;
  } cell_t;

endpackage

/* design/dcs_ram.sv */
// Generic single-port-write RAM with registered read.
module dcs_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dcs_cell.sv */
// One Golay encoder cell: a single LFSR step, registered, with its entry riding along.
module dcs_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          flush,
  input  dcs_pkg::cell_t cell_in,
  output dcs_pkg::cell_t cell_out
);

  logic [dcs_pkg::LFSR_W:0]   shifted;
  logic [dcs_pkg::LFSR_W-1:0] stepped;
  logic                       valid;
  logic [dcs_pkg::IDX_W-1:0]  idx;
  logic [dcs_pkg::CODE_W-1:0] code;
  logic [dcs_pkg::LFSR_W-1:0] lfsr;

  // shift left, fold in the polynomial when the top bit falls out
  always_comb begin
    shifted = {cell_in.lfsr, 1'b0};
    stepped = shifted[dcs_pkg::LFSR_W] ? (shifted[dcs_pkg::LFSR_W-1:0] ^ dcs_pkg::GOLAY_POLY)
                                       : shifted[dcs_pkg::LFSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      valid <= 1'b0;
    end else begin
      valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= cell_in.idx;
    code <= cell_in.code;
    lfsr <= stepped;
  end

  assign cell_out = '{valid: valid, idx: idx, code: code, lfsr: lfsr};

endmodule

/* design/dcs_golay_detector.sv */
// Top level: code table, scan sequencer and Golay encoder cell row.
//
// Usage:
//  - s_* channel takes items. s_tuser selects the kind: load (0) writes entry_code
//    into table slot entry_index; detect (1) searches received_word. Loads beyond
//    the table are dropped. A load gives no result.
//  - m_* channel gives one item per detect: m_tuser = found, m_tdata holds the
//    matching index and its stored code (both zero when nothing matched).
//  - cfg_we/cfg_data write last_index (reset 104), the highest slot searched.
//  - A detect walks ROTATIONS shifted forms of the word. A form
//    whose bits 11..9 read 100b scans slots 1..min(last_index, TABLE_DEPTH-1),
//    one RAM read per cycle, through a row of 12 encoder cells. At most every
//    third form can carry the marker; the encoder latency and the single table
//    read port set the worst-case search time. The scan stops at the first hit.
//  - One item is worked on at a time: s_tready is high only between detects.
//  - A finished result sits in the output register; when the receiver stalls,
//    the next detect may be taken but its result waits until the register frees.
//  - Reset (rst, synchronous) clears the control state and last_index; table
//    contents are undefined until loaded.
module dcs_golay_detector #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned ROTATIONS   = 23
) (
  input  logic                           clk,
  input  logic                           rst,
  // entry_index[6:0], entry_code[15:7], received_word[39:16]
  input  logic [dcs_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // match_index[6:0], match_code[15:7]
  output logic [dcs_pkg::M_DATA_W-1:0]   m_tdata,
  // found
  output logic                           m_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [dcs_pkg::IDX_W-1:0]      cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned RW = $clog2(ROTATIONS + 1);
  localparam logic [RW-1:0] ROT_LAST = RW'(ROTATIONS - 1);
  localparam int unsigned STEPS = dcs_pkg::GOLAY_STEPS;

  dcs_pkg::state_t state, state_next;

  logic [dcs_pkg::IDX_W-1:0]  last_index;
  logic [dcs_pkg::IDX_W-1:0]  lim;
  logic [dcs_pkg::WORD_W-1:0] word, word_next;
  logic [RW-1:0]              rot, rot_next;
  logic [dcs_pkg::IDX_W-1:0]  idx, idx_next;
  logic                       issue_q, issue_next;
  logic [dcs_pkg::IDX_W-1:0]  idx_q;
  logic                       res_found, res_found_next;
  logic [dcs_pkg::IDX_W-1:0]  res_idx, res_idx_next;
  logic [dcs_pkg::CODE_W-1:0] res_code, res_code_next;
  logic                       flush;
  logic                       busy;
  logic                       hit;
  logic [dcs_pkg::WORD_W-1:0] codeword;
  logic [dcs_pkg::WORD_W-1:0] word_step;

  logic [dcs_pkg::IDX_W-1:0]  in_idx;
  logic [dcs_pkg::CODE_W-1:0] in_code;
  logic [dcs_pkg::WORD_W-1:0] in_word;
  logic                       ram_we;
  logic [dcs_pkg::CODE_W-1:0] ram_rdata;

  dcs_pkg::cell_t chain [STEPS+1];

  // input unpacking
  assign in_idx  = s_tdata[6:0];
  assign in_code = s_tdata[15:7];
  assign in_word = s_tdata[39:16];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= dcs_pkg::LAST_INDEX_RESET;
    end else if (cfg_we) begin
      last_index <= cfg_data;
    end
  end

  // search limit, clipped to the table
  assign lim = (int'(last_index) > int'(TABLE_DEPTH) - 1) ? dcs_pkg::IDX_W'(TABLE_DEPTH - 1)
                                                         : last_index;

  // code table
  assign s_tready = (state == dcs_pkg::ST_IDLE);
  assign ram_we   = s_tvalid && s_tready && (s_tuser == dcs_pkg::OP_LOAD)
                    && (int'(in_idx) < int'(TABLE_DEPTH));

  dcs_ram #(
    .WIDTH (dcs_pkg::CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_idx)),
    .wdata (in_code),
    .raddr (AW'(idx)),
    .rdata (ram_rdata)
  );

  // encoder cell row, fed with each entry as it leaves the RAM
  assign chain[0] = '{valid: issue_q,
                      idx:   idx_q,
                      code:  ram_rdata,
                      lfsr:  {dcs_pkg::DATA_MARK, ram_rdata}};

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    dcs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .flush    (flush),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // compare the finished codeword with the current form of the word
  assign codeword = {1'b0, chain[STEPS].lfsr[dcs_pkg::LFSR_W-1:1], dcs_pkg::DATA_MARK,
                     chain[STEPS].code};
  assign hit      = chain[STEPS].valid && (codeword == word);

  // entries still on their way to the compare
  always_comb begin
    busy = issue_q;
    for (int k = 1; k < STEPS; k++) begin
      busy = busy | chain[k].valid;
    end
  end

  // bit 0 folds into bit 23, then the word shifts right
  assign word_step = {1'b0, word[23] | word[0], word[22:1]};

  // sequencer
  always_comb begin
    state_next     = state;
    word_next      = word;
    rot_next       = rot;
    idx_next       = idx;
    issue_next     = 1'b0;
    res_found_next = res_found;
    res_idx_next   = res_idx;
    res_code_next  = res_code;
    flush          = 1'b0;

    unique case (state)
      dcs_pkg::ST_IDLE: begin
        if (s_tvalid && (s_tuser == dcs_pkg::OP_DETECT)) begin
          word_next  = in_word;
          rot_next   = '0;
          state_next = dcs_pkg::ST_ROT;
        end
      end
      dcs_pkg::ST_ROT: begin
        if ((word[11:9] == dcs_pkg::DATA_MARK) && (lim != '0)) begin
          idx_next   = dcs_pkg::IDX_W'(1);
          state_next = dcs_pkg::ST_SCAN;
        end else if (rot == ROT_LAST) begin
          res_found_next = 1'b0;
          res_idx_next   = '0;
          res_code_next  = '0;
          state_next     = dcs_pkg::ST_FINISH;
        end else begin
          word_next = word_step;
          rot_next  = rot + RW'(1);
        end
      end
      dcs_pkg::ST_SCAN: begin
        if (hit) begin
          res_found_next = 1'b1;
          res_idx_next   = chain[STEPS].idx;
          res_code_next  = chain[STEPS].code;
          flush          = 1'b1;
          state_next     = dcs_pkg::ST_FINISH;
        end else begin
          issue_next = 1'b1;
          if (idx == lim) begin
            state_next = dcs_pkg::ST_DRAIN;
          end else begin
            idx_next = idx + dcs_pkg::IDX_W'(1);
          end
        end
      end
      dcs_pkg::ST_DRAIN: begin
        if (hit) begin
          res_found_next = 1'b1;
          res_idx_next   = chain[STEPS].idx;
          res_code_next  = chain[STEPS].code;
          flush          = 1'b1;
          state_next     = dcs_pkg::ST_FINISH;
        end else if (!busy) begin
          if (rot == ROT_LAST) begin
            res_found_next = 1'b0;
            res_idx_next   = '0;
            res_code_next  = '0;
            state_next     = dcs_pkg::ST_FINISH;
          end else begin
            word_next  = word_step;
            rot_next   = rot + RW'(1);
            state_next = dcs_pkg::ST_ROT;
          end
        end
      end
      dcs_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = dcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcs_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dcs_pkg::ST_IDLE;
      issue_q <= 1'b0;
    end else begin
      state   <= state_next;
      issue_q <= issue_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    word      <= word_next;
    rot       <= rot_next;
    idx       <= idx_next;
    idx_q     <= idx;
    res_found <= res_found_next;
    res_idx   <= res_idx_next;
    res_code  <= res_code_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == dcs_pkg::ST_FINISH) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == dcs_pkg::ST_FINISH) && (!m_tvalid || m_tready)) begin
      m_tuser <= res_found;
      m_tdata <= {res_code, res_idx};
    end
  end

endmodule

/* design/dcs_checker.sv */
// Port-level checks for the DCS detector, bound to the top level.
module dcs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic                         m_tuser,
  input logic [dcs_pkg::M_DATA_W-1:0] m_tdata
);

  // a miss reports zero index and code
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with non-zero payload");

  // slot 0 is never searched
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[6:0] != '0)
    else $error("hit at slot 0");

  // an accepted detect keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == dcs_pkg::OP_DETECT) |=> !s_tready)
    else $error("detect did not start a search");

  // a new result only appears out of a search in progress
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a search");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind dcs_golay_detector dcs_checker u_dcs_checker (.*);
